// ----- sv/jdcd_pkg.sv -----
// ----------------------------------------------------------------------------
// jdcd_pkg
// Types and constants shared by the Julian day to calendar date pipeline.
// ----------------------------------------------------------------------------
package jdcd_pkg;

  localparam int unsigned FracBits  = 40;
  localparam int unsigned NumStages = 9;

  typedef struct packed {
    logic [22:0]         julian_day;
    logic [FracBits-1:0] day_fraction;
  } jdcd_in_t;

  typedef struct packed {
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
  } jdcd_out_t;

  // stage k advances when bit k is set
  typedef logic [NumStages:1] stage_en_t;

  // exact floor division by constants: q = (x * ceil(2^k / D)) >> k
  localparam logic [23:0] GregStart = 24'd2299160;
  localparam logic [24:0] GregBias  = 25'd7468865;

  localparam int unsigned DivAShift = 43;
  localparam logic [25:0] DivAMul   =
    26'(((64'd1 << DivAShift) + 64'd146096) / 64'd146097);

  localparam int unsigned DivDShift = 46;
  localparam logic [30:0] DivDMul   =
    31'(((64'd1 << DivDShift) + 64'd36524) / 64'd36525);

  // 10000 * ceil(2^42 / 306001), folded so the 10000 * y step disappears
  localparam int unsigned DivGShift = 42;
  localparam logic [37:0] DivGMul   =
    38'((((64'd1 << DivGShift) + 64'd306000) / 64'd306001) * 64'd10000);

  localparam int unsigned DivHrShift = 29;
  localparam logic [17:0] DivHrMul   =
    18'(((64'd1 << DivHrShift) + 64'd3599) / 64'd3600);

  localparam int unsigned DivMinShift = 23;
  localparam logic [17:0] DivMinMul   =
    18'(((64'd1 << DivMinShift) + 64'd59) / 64'd60);

endpackage

// ----- sv/jdcd_date.sv -----
// ----------------------------------------------------------------------------
// jdcd_date
// Day number to year, month and day of month, stages 2 to 9.
// ----------------------------------------------------------------------------
module jdcd_date (
  input  logic                 clk_i,
  input  jdcd_pkg::stage_en_t  en_i,
  input  logic [23:0]          jd_i,
  output logic signed [15:0]   year_o,
  output logic [3:0]           month_o,
  output logic [4:0]           day_of_month_o
);
  import jdcd_pkg::*;

  // floor(30.6001 * g)
  function automatic logic [8:0] month_span(input logic [3:0] g);
    logic [8:0] r;
    case (g)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

  logic        greg2_q, greg3_q;
  logic [24:0] xa2_q;
  logic [23:0] jd2_q, jd3_q;
  logic [7:0]  a3_q;
  logic [23:0] c4_q, c5_q, c6_q;
  logic [29:0] x5_q;
  logic [14:0] d6_q, d7_q, d8_q;
  logic [8:0]  y7_q, y8_q;
  logic [3:0]  g8_q;

  logic [50:0] a_prod;
  logic [60:0] d_prod;
  logic [46:0] g_prod;
  logic [23:0] b_d;
  logic [24:0] e_d;
  logic [3:0]  mon_d;
  logic [4:0]  dom_d;
  logic signed [15:0] yr_d;

  always_comb begin
    a_prod = 51'(xa2_q) * 51'(DivAMul);
    b_d    = greg3_q ? (jd3_q + 24'd1 + 24'(a3_q) - 24'(a3_q >> 2)) : jd3_q;
    d_prod = 61'(x5_q) * 61'(DivDMul);
    e_d    = 25'((26'(d6_q) * 26'd1461) >> 2);
    g_prod = 47'(y7_q) * 47'(DivGMul);
    dom_d  = 5'(y8_q - month_span(g8_q));
    mon_d  = (g8_q < 4'd14) ? (g8_q - 4'd1) : (g8_q - 4'd13);
    yr_d   = $signed({1'b0, d8_q}) - ((mon_d > 4'd2) ? 16'sd4716 : 16'sd4715);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      greg2_q <= (jd_i > GregStart);
      xa2_q   <= 25'({jd_i, 2'b00} - 26'(GregBias));
      jd2_q   <= jd_i;
    end
    if (en_i[3]) begin
      a3_q    <= a_prod[DivAShift +: 8];
      greg3_q <= greg2_q;
      jd3_q   <= jd2_q;
    end
    if (en_i[4]) begin
      c4_q <= b_d + 24'd1524;
    end
    if (en_i[5]) begin
      x5_q <= (30'(c4_q) << 6) + (30'(c4_q) << 5) + (30'(c4_q) << 2) - 30'd12210;
      c5_q <= c4_q;
    end
    if (en_i[6]) begin
      d6_q <= d_prod[DivDShift +: 15];
      c6_q <= c5_q;
    end
    if (en_i[7]) begin
      y7_q <= 9'(25'(c6_q) - e_d);
      d7_q <= d6_q;
    end
    if (en_i[8]) begin
      g8_q <= g_prod[DivGShift +: 4];
      y8_q <= y7_q;
      d8_q <= d7_q;
    end
    if (en_i[9]) begin
      year_o         <= yr_d;
      month_o        <= mon_d;
      day_of_month_o <= dom_d;
    end
  end

endmodule

// ----- sv/jdcd_time.sv -----
// ----------------------------------------------------------------------------
// jdcd_time
// Day fraction to hour, minute and rounded second, stages 2 to 9.
// ----------------------------------------------------------------------------
module jdcd_time (
  input  logic                          clk_i,
  input  jdcd_pkg::stage_en_t           en_i,
  input  logic [jdcd_pkg::FracBits-1:0] fr_i,
  output logic [4:0]                    hour_o,
  output logic [5:0]                    minute_o,
  output logic [5:0]                    second_o
);
  import jdcd_pkg::*;

  localparam int unsigned FirstDelay = 5;

  logic [FracBits+9:0] scaled;
  logic [16:0]         tot2_q, tot3_q;
  logic                rnd2_q, rnd3_q;
  logic [4:0]          hr3_q;
  logic [10:0]         q60_3_q;
  logic [34:0]         hr_prod, q60_prod;
  logic [5:0]          mn_d, sc_raw, sc_d;

  logic [4:0] hr_q [4:NumStages];
  logic [5:0] mn_q [4:NumStages];
  logic [5:0] sc_q [4:NumStages];

  // fraction * 675 = fraction * 86400 / 128
  always_comb begin
    scaled   = (50'(fr_i) << 9) + (50'(fr_i) << 7) + (50'(fr_i) << 5)
             + (50'(fr_i) << 1) + 50'(fr_i);
    hr_prod  = 35'(tot2_q) * 35'(DivHrMul);
    q60_prod = 35'(tot2_q) * 35'(DivMinMul);
    mn_d     = 6'(11'(q60_3_q) - 11'(hr3_q) * 11'd60);
    sc_raw   = 6'(tot3_q - 17'(q60_3_q) * 17'd60);
    sc_d     = (rnd3_q && sc_raw < 6'd59) ? sc_raw + 6'd1 : sc_raw;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      tot2_q <= scaled[FracBits-7 +: 17];
      rnd2_q <= scaled[FracBits-8];
    end
    if (en_i[3]) begin
      hr3_q   <= hr_prod[DivHrShift +: 5];
      q60_3_q <= q60_prod[DivMinShift +: 11];
      tot3_q  <= tot2_q;
      rnd3_q  <= rnd2_q;
    end
    if (en_i[4]) begin
      hr_q[4] <= hr3_q;
      mn_q[4] <= mn_d;
      sc_q[4] <= sc_d;
    end
    for (int k = FirstDelay; k <= NumStages; k++) begin
      if (en_i[k]) begin
        hr_q[k] <= hr_q[k-1];
        mn_q[k] <= mn_q[k-1];
        sc_q[k] <= sc_q[k-1];
      end
    end
  end

  assign hour_o   = hr_q[NumStages];
  assign minute_o = mn_q[NumStages];
  assign second_o = sc_q[NumStages];

endmodule

// ----- sv/julian_day_to_calendar_date.sv -----
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date
// Julian day number and binary day fraction to calendar date and time of day.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// cfg      in         cfg_valid_i / cfg_ready_o cfg_data_i (add_half_day)
// in       in         in_valid_i / in_ready_o   jdcd_in_t
// out      out        out_valid_o / out_ready_i jdcd_out_t
//
// Nine register stages; one request per cycle while the output is not stalled.
// Depth is set by the reciprocal multipliers of the date chain.
// Each stage holds while the one after it is full and stalled; bubbles close.
// Reset empties the pipeline and clears add_half_day; cfg is always ready.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jdcd_pkg::jdcd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jdcd_pkg::jdcd_out_t out_data_o
);
  import jdcd_pkg::*;

  logic                  add_half_day_q;
  logic [NumStages:1]    valid_q;
  stage_en_t             en;
  logic [FracBits:0]     fr_sum;
  logic [23:0]           jd1_q;
  logic [FracBits-1:0]   fr1_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_half_day_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      add_half_day_q <= cfg_data_i;
    end
  end

  always_comb begin
    en[NumStages] = !valid_q[NumStages] || out_ready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = valid_q[NumStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) valid_q[1] <= in_valid_i;
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // half-day offset, carry into the day number
  assign fr_sum = {1'b0, in_data_i.day_fraction}
                + {1'b0, add_half_day_q, {(FracBits-1){1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      jd1_q <= {1'b0, in_data_i.julian_day} + 24'(fr_sum[FracBits]);
      fr1_q <= fr_sum[FracBits-1:0];
    end
  end

  jdcd_date u_date (
    .clk_i          (clk_i),
    .en_i           (en),
    .jd_i           (jd1_q),
    .year_o         (out_data_o.year),
    .month_o        (out_data_o.month),
    .day_of_month_o (out_data_o.day_of_month)
  );

  jdcd_time u_time (
    .clk_i    (clk_i),
    .en_i     (en),
    .fr_i     (fr1_q),
    .hour_o   (out_data_o.hour),
    .minute_o (out_data_o.minute),
    .second_o (out_data_o.second)
  );

`ifndef SYNTH
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[1])
    else $error("accepted request not captured in first stage");

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage empty");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && !out_ready_i |-> !in_ready_o)
    else $error("full pipeline accepted a request");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.minute <= 6'd59 && out_data_o.second <= 6'd59
                    && out_data_o.hour <= 5'd23)
    else $error("time of day out of range");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.month >= 4'd1 && out_data_o.month <= 4'd12)
    else $error("month out of range");
`endif

endmodule

// ----- test/julian_day_to_calendar_date_test.sv -----
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_test
// Drives Julian day requests through the converter under both half-day
// settings and checks every date and time of day against a local predictor.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jdcd_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned TailCycles = NumStages * 4;
  localparam int unsigned RandomItems = 100;
  localparam longint unsigned FracMask = (64'd1 << FracBits) - 64'd1;
  localparam logic [22:0] DayMax = 23'h7FFFFF;
  localparam logic [22:0] GregDay = 23'd2299160;

  class date_scoreboard;
    jdcd_out_t   pending[$];
    bit          half_day;
    int unsigned mismatches;

    function jdcd_out_t convert(jdcd_in_t req);
      jdcd_out_t       res;
      longint unsigned jd, fr, a, b, c, d, e, g, dom, mon;
      longint unsigned scaled, tot, rem, hr, mn, sc;
      longint          yr;
      jd = req.julian_day;
      fr = req.day_fraction & FracMask;
      if (half_day) begin
        fr += 64'd1 << (FracBits - 1);
        if (fr > FracMask) begin
          fr &= FracMask;
          jd += 1;
        end
      end
      if (jd > GregDay) begin
        a = (4 * jd - 7468865) / 146097;
        b = jd + 1 + a - a / 4;
      end else begin
        b = jd;
      end
      c   = b + 1524;
      d   = (100 * c - 12210) / 36525;
      e   = (1461 * d) / 4;
      g   = (10000 * (c - e)) / 306001;
      dom = c - e - (306001 * g) / 10000;
      mon = (g < 14) ? g - 1 : g - 13;
      yr  = longint'(d) - ((mon > 2) ? 4716 : 4715);

      scaled = fr * 675;
      tot    = scaled >> (FracBits - 7);
      rem    = scaled & ((64'd1 << (FracBits - 7)) - 64'd1);
      hr     = tot / 3600;
      mn     = (tot / 60) % 60;
      sc     = tot % 60;
      // round half up, but never past 59
      if (rem >= (64'd1 << (FracBits - 8)) && sc < 59) sc++;

      res.year         = 16'(yr);
      res.month        = 4'(mon);
      res.day_of_month = 5'(dom);
      res.hour         = 5'(hr);
      res.minute       = 6'(mn);
      res.second       = 6'(sc);
      return res;
    endfunction

    function void note_request(jdcd_in_t req);
      pending.push_back(convert(req));
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(jdcd_out_t got);
      jdcd_out_t want;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("year", longint'(want.year), longint'(got.year));
      compare_field("month", want.month, got.month);
      compare_field("day_of_month", want.day_of_month, got.day_of_month);
      compare_field("hour", want.hour, got.hour);
      compare_field("minute", want.minute, got.minute);
      compare_field("second", want.second, got.second);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;
  logic      in_valid;
  logic      in_ready;
  jdcd_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  jdcd_out_t out_data;

  date_scoreboard sb;
  int unsigned    idle_cycles;

  julian_day_to_calendar_date u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: notes requests, checks results, and watches for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.half_day = cfg_data;
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver stall pattern
  initial begin
    int unsigned mode;
    int unsigned len;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 40);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  function automatic jdcd_in_t make_request(logic [22:0] jd, logic [FracBits-1:0] fr);
    jdcd_in_t req;
    req.julian_day   = jd;
    req.day_fraction = fr;
    return req;
  endfunction

  // smallest fraction whose remainder reaches half a second past sec, plus off
  function automatic logic [FracBits-1:0] half_second_frac(int unsigned sec, int off);
    longint unsigned k;
    k = 2 * longint'(sec) + 1;
    return FracBits'((((k << (FracBits - 8)) + 674) / 675) + off);
  endfunction

  function automatic logic [22:0] random_day();
    case ($urandom_range(0, 9))
      0, 1: return GregDay - 23'd1000 + 23'($urandom_range(0, 2000));
      2:    return DayMax - 23'($urandom_range(0, 1500));
      3:    return 23'($urandom_range(0, 1500));
      4, 5: return 23'($urandom_range(2400000, 2500000));
      default: return 23'($urandom);
    endcase
  endfunction

  function automatic logic [FracBits-1:0] random_frac();
    if ($urandom_range(0, 9) < 6) return FracBits'({$urandom, $urandom});
    return half_second_frac($urandom_range(0, 86399), $urandom_range(0, 4) - 2);
  endfunction

  task automatic send_request(jdcd_in_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_config(logic half);
    cfg_data  <= half;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed(logic half);
    write_config(half);
    send_request(make_request(23'd0, '0));
    send_request(make_request(DayMax, '1));
    send_request(make_request(DayMax, FracBits'(FracMask >> 1)));
    send_request(make_request(GregDay, '0));
    send_request(make_request(GregDay + 23'd1, '0));
    send_request(make_request(23'd2451545, FracBits'(64'd1 << (FracBits - 1))));
    send_request(make_request(23'd2451545, half_second_frac(754, 0)));
    send_request(make_request(23'd2451545, half_second_frac(754, -1)));
    send_request(make_request(23'd2451545, half_second_frac(3599, 0)));
    send_request(make_request(23'd2299159, half_second_frac(86399, 0)));
    send_request(make_request(23'h2AAAAA, FracBits'(64'h55_5555_5555)));
    send_request(make_request(23'h555555, FracBits'(64'hAA_AAAA_AAAA)));
    drain();
  endtask

  task automatic run_random(logic half, bit mid_pause);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    write_config(half);
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        if (sent < RandomItems) begin
          send_request(make_request(random_day(), random_frac()));
          sent++;
          if (mid_pause && sent == RandomItems / 2) drain();
        end
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 12));
    end
    drain();
  endtask

  initial begin
    sb          = new();
    idle_cycles = 0;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed(1'b0);
    run_directed(1'b1);
    run_random(1'b1, 1'b0);
    run_random(1'b0, 1'b1);
    run_random(1'b1, 1'b0);
    run_random(1'b0, 1'b0);

    repeat (TailCycles) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/jdcd_pkg.sv
sv/jdcd_date.sv
sv/jdcd_time.sv
sv/julian_day_to_calendar_date.sv
test/julian_day_to_calendar_date_test.sv
